// ===== src/dsc_pkg.sv =====
// Shared types and constants for the divisor sum classifier.
// No dependencies; imported by dsc_if, dsc_datapath, dsc_ctrl and divisor_sum_classifier.
`timescale 1ns / 1ps

package dsc_pkg;

	localparam int VALUE_BITS_DEF = 16;
	localparam int ALIQUOT_BITS   = 18;
	localparam logic [ALIQUOT_BITS-1:0] ALIQUOT_MAX = '1;

	typedef enum logic [1:0] {
		CLASS_DEFICIENT = 2'd0,
		CLASS_PERFECT   = 2'd1,
		CLASS_ABUNDANT  = 2'd2
	} class_t;

	// what a multiply result is written back to
	typedef enum logic [1:0] {
		MUL_POWER = 2'd0,  // power term times divisor, plus one
		MUL_SIGMA = 2'd1,  // divisor sum times power term
		MUL_LEFT  = 2'd2   // divisor sum times (leftover + 1)
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		logic     div_apply;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     mul_wb;
		logic     res_load;
	} dsc_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic mul_busy;
		logic rem_zero;
		logic dsq_gt;
		logic left_gt1;
		logic n_zero;
	} dsc_status_t;

endpackage

// ===== src/dsc_if.sv =====
// Valid/ready channel interfaces for the value and result items.
// Depends on dsc_pkg for the result field widths.
`timescale 1ns / 1ps

interface dsc_value_if #(
	parameter int VALUE_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface dsc_result_if
	import dsc_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [1:0]              number_class;
	logic [ALIQUOT_BITS-1:0] aliquot_sum;

	modport source (output valid, output number_class, output aliquot_sum, input ready);
	modport sink   (input valid, input number_class, input aliquot_sum, output ready);
endinterface

// ===== src/dsc_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by dsc_datapath.
`timescale 1ns / 1ps

module dsc_divider #(
	parameter int VB = 16,
	parameter int DB = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [VB-1:0] dividend,
	input  logic [DB-1:0] divisor,
	output logic          busy,
	output logic [VB-1:0] quotient,
	output logic [DB-1:0] remainder
);

	localparam int CW = $clog2(VB + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [VB-1:0] q_q;
	logic [DB-1:0] r_q;
	logic [DB-1:0] d_q;
	logic [DB:0]   r_sh;
	logic          ge;

	assign r_sh = {r_q, q_q[VB-1]};
	assign ge   = r_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(VB);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CW'(1);
			busy_q <= cnt_q != CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[VB-2:0], ge};
			r_q <= ge ? DB'(r_sh - {1'b0, d_q}) : DB'(r_sh);
		end
	end

	assign busy      = busy_q;
	assign quotient  = q_q;
	assign remainder = r_q;

endmodule

// ===== src/dsc_multiplier.sv =====
// Shift-add multiplier; it stops once no set bit of the second operand remains.
// Depends on nothing; used by dsc_datapath. Product is kept to W bits.
`timescale 1ns / 1ps

module dsc_multiplier #(
	parameter int W = 19
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         busy,
	output logic [W-1:0] product
);

	logic         busy_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic [W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (b_q >> 1) == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy    = busy_q;
	assign product = acc_q;

endmodule

// ===== src/dsc_datapath.sv =====
// Datapath: factoring registers, divider, multiplier and the result register.
// Depends on dsc_pkg, dsc_divider and dsc_multiplier.
`timescale 1ns / 1ps

module dsc_datapath
	import dsc_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dsc_cmd_t                cmd,
	output dsc_status_t             status,
	input  logic [VALUE_BITS-1:0]   value,
	output logic [1:0]              number_class,
	output logic [ALIQUOT_BITS-1:0] aliquot_sum
);

	localparam int VB = VALUE_BITS;
	localparam int DB = (VB + 1) / 2 + 1;   // trial divisor
	localparam int SB = 2 * DB;             // divisor squared
	localparam int AB = VB + 3;             // sigma(n) < 8n over the whole range
	localparam int CB = (AB > ALIQUOT_BITS) ? AB : ALIQUOT_BITS;

	logic [VB-1:0] n_q;
	logic [VB-1:0] rem_q;
	logic [DB-1:0] d_q;
	logic [SB-1:0] dsq_q;
	logic [AB-1:0] sigma_q;
	logic [AB-1:0] pt_q;
	mul_sel_t      sel_q;
	class_t        class_q;
	logic [ALIQUOT_BITS-1:0] aliq_q;

	logic          div_busy;
	logic [VB-1:0] quot;
	logic [DB-1:0] rmd;
	logic          mul_busy;
	logic [AB-1:0] mul_a;
	logic [AB-1:0] mul_b;
	logic [AB-1:0] prod;

	logic [AB-1:0] aliq_full;
	logic [CB-1:0] aliq_ext;
	logic [CB-1:0] n_ext;
	class_t        class_d;
	logic [ALIQUOT_BITS-1:0] aliq_d;

	dsc_divider #(.VB(VB), .DB(DB)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (rem_q),
		.divisor   (d_q),
		.busy      (div_busy),
		.quotient  (quot),
		.remainder (rmd)
	);

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_POWER: begin
				mul_a = pt_q;
				mul_b = AB'(d_q);
			end
			MUL_SIGMA: begin
				mul_a = sigma_q;
				mul_b = pt_q;
			end
			MUL_LEFT: begin
				mul_a = sigma_q;
				mul_b = AB'(rem_q) + AB'(1);
			end
			default: begin
				mul_a = sigma_q;
				mul_b = pt_q;
			end
		endcase
	end

	dsc_multiplier #(.W(AB)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.busy    (mul_busy),
		.product (prod)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q     <= value;
			rem_q   <= value;
			d_q     <= DB'(2);
			dsq_q   <= SB'(4);
			sigma_q <= AB'(1);
			pt_q    <= AB'(1);
		end else begin
			if (cmd.div_apply) begin
				rem_q <= quot;
			end
			if (cmd.mul_start) begin
				sel_q <= cmd.mul_sel;
			end
			if (cmd.mul_wb) begin
				unique case (sel_q)
					MUL_POWER: pt_q <= prod + AB'(1);
					MUL_SIGMA: begin
						sigma_q <= prod;
						pt_q    <= AB'(1);
						d_q     <= d_q + DB'(1);
						// (d+1)^2 = d^2 + 2d + 1
						dsq_q   <= dsq_q + SB'({d_q, 1'b0}) + SB'(1);
					end
					MUL_LEFT:  sigma_q <= prod;
					default:   sigma_q <= sigma_q;
				endcase
			end
		end
	end

	// aliquot sum, class decided on the exact sum, output saturated
	assign aliq_full = sigma_q - AB'(n_q);
	assign aliq_ext  = CB'(aliq_full);
	assign n_ext     = CB'(n_q);

	always_comb begin
		if (n_q == '0) begin
			class_d = CLASS_DEFICIENT;
			aliq_d  = '0;
		end else begin
			if (aliq_ext == n_ext) begin
				class_d = CLASS_PERFECT;
			end else if (aliq_ext < n_ext) begin
				class_d = CLASS_DEFICIENT;
			end else begin
				class_d = CLASS_ABUNDANT;
			end
			aliq_d = (aliq_ext > CB'(ALIQUOT_MAX)) ? ALIQUOT_MAX : ALIQUOT_BITS'(aliq_ext);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			class_q <= class_d;
			aliq_q  <= aliq_d;
		end
	end

	assign status.div_busy = div_busy;
	assign status.mul_busy = mul_busy;
	assign status.rem_zero = rmd == '0;
	assign status.dsq_gt   = dsq_q > SB'(rem_q);
	assign status.left_gt1 = rem_q > VB'(1);
	assign status.n_zero   = n_q == '0;

	assign number_class = class_q;
	assign aliquot_sum  = aliq_q;

`ifndef NO_ASSERTIONS
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider restarted while busy");
	a_mul_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !mul_busy && !div_busy)
		else $error("multiplier started while a unit is busy");
`endif

endmodule

// ===== src/dsc_ctrl.sv =====
// Controller: sequences trial division, multiplies and the result handshake.
// Depends on dsc_pkg; drives dsc_datapath through dsc_cmd_t.
`timescale 1ns / 1ps

module dsc_ctrl
	import dsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  dsc_status_t status,
	output dsc_cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_CHECK    = 7'b0000010,
		ST_DIV      = 7'b0000100,
		ST_MUL_POW  = 7'b0001000,
		ST_MUL_SIG  = 7'b0010000,
		ST_MUL_LEFT = 7'b0100000,
		ST_FINISH   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.mul_sel = MUL_SIGMA;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.n_zero) begin
					state_d = ST_FINISH;
				end else if (status.dsq_gt) begin
					if (status.left_gt1) begin
						cmd.mul_start = 1'b1;
						cmd.mul_sel   = MUL_LEFT;
						state_d       = ST_MUL_LEFT;
					end else begin
						state_d = ST_FINISH;
					end
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!status.div_busy) begin
					cmd.mul_start = 1'b1;
					if (status.rem_zero) begin
						// divides: keep the quotient, extend the power term
						cmd.div_apply = 1'b1;
						cmd.mul_sel   = MUL_POWER;
						state_d       = ST_MUL_POW;
					end else begin
						cmd.mul_sel = MUL_SIGMA;
						state_d     = ST_MUL_SIG;
					end
				end
			end
			ST_MUL_POW: begin
				if (!status.mul_busy) begin
					cmd.mul_wb    = 1'b1;
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_MUL_SIG: begin
				if (!status.mul_busy) begin
					cmd.mul_wb = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_MUL_LEFT: begin
				if (!status.mul_busy) begin
					cmd.mul_wb = 1'b1;
					state_d    = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !out_valid_q || out_ready)
		else $error("pending result item overwritten");
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !status.div_busy && !status.mul_busy)
		else $error("arithmetic unit busy while idle");
`endif

endmodule

// ===== src/divisor_sum_classifier.sv =====
// Divisor sum classifier: takes a value item, returns its aliquot sum and class.
// Usage: "values" is a valid/ready sink carrying one VALUE_BITS-wide value per item;
// "results" is a valid/ready source carrying number_class (0 deficient,
// 1 perfect, 2 abundant) and aliquot_sum (18 bits, saturating), one per value.
// The value is factored by trial divisors 2, 3, ... while d*d <= remaining.
// Each trial takes one division through the restoring divider, one shift-add
// multiply and one check state; every repeated prime factor adds one more
// division and a multiply by the divisor. A value of 16 bits does worst as a
// prime above 65025, which takes 254 trials. One value is worked on at a
// time; values.ready is high only when no item is in progress. The result
// sits in an output register: the next value is taken while it waits, and if
// results.ready is low when the next result is done, the block holds in its
// final state until the register frees up.
// Reset (arst_n low) clears the controller and drops any pending result.
// Depends on dsc_pkg, dsc_if, dsc_ctrl and dsc_datapath.
`timescale 1ns / 1ps

module divisor_sum_classifier
	import dsc_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	dsc_value_if.sink    values,
	dsc_result_if.source results
);

	dsc_cmd_t    cmd;
	dsc_status_t status;

	dsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (values.valid),
		.in_ready  (values.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	dsc_datapath #(.VALUE_BITS(VALUE_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.value        (values.value),
		.number_class (results.number_class),
		.aliquot_sum  (results.aliquot_sum)
	);

endmodule
